// ===== hdl/ntcu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcu_pkg
// Opcodes, work kinds, format constants and the pipeline word of the
// numeric type conversion unit.
// ----------------------------------------------------------------------------
package ntcu_pkg;

  // Conversion select
  typedef enum logic [4:0] {
    OP_I32_F64 = 5'd0, OP_I32_I64, OP_F64_I32, OP_I64_I32, OP_F32_F64,
    OP_F64_F32, OP_I32_F32, OP_I64_F64, OP_I64_F32, OP_F64_I64,
    OP_F32_I32, OP_F32_I64, OP_I8_I32, OP_I16_I32, OP_I8_I64,
    OP_I16_I64, OP_U8_U32, OP_U16_U32, OP_U8_U64, OP_U16_U64,
    OP_U32_U64, OP_U32_I64, OP_I32_I8, OP_I32_I16, OP_U32_U8,
    OP_U32_U16, OP_I32_U32, OP_U32_I32, OP_I64_U64, OP_U64_I64
  } op_t;

  // What the later stages still have to do with a word
  typedef enum logic [1:0] {
    KIND_INT  = 2'd0,  // result final in res
    KIND_PACK = 2'd1,  // round m * 2^q into a float format
    KIND_F2I  = 2'd2   // truncate a float to an integer
  } kind_t;

  localparam int QW = 13;

  localparam logic signed [QW-1:0] BIAS32    = 13'sd127;
  localparam logic signed [QW-1:0] BIAS64    = 13'sd1023;
  localparam logic signed [QW-1:0] MAXEXP32  = 13'sd255;
  localparam logic signed [QW-1:0] MAXEXP64  = 13'sd2047;
  localparam logic signed [QW-1:0] DROP32    = 13'sd40;   // 64 - 24
  localparam logic signed [QW-1:0] DROP64    = 13'sd11;   // 64 - 53
  localparam logic signed [QW-1:0] DROP_FULL = 13'sd64;

  typedef struct packed {
    kind_t                  kind;
    logic                   to32;    // pack target is f32
    logic                   n64;     // integer target is 64 bits
    logic                   neg;
    logic                   trap;
    logic [63:0]            res;
    logic [63:0]            m;       // magnitude, later shifted value
    logic signed [QW-1:0]   q;       // exponent, later biased exponent
    logic [5:0]             lz;
    logic                   frac;
    logic                   big;
    logic [6:0]             drop;
    logic                   guard;
    logic                   sticky;
  } pipe_t;

endpackage

// ===== hdl/ntcu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcu_in_if / ntcu_out_if
// Valid/ready channels carrying conversion requests and results.
// ----------------------------------------------------------------------------
interface ntcu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  opcode;
  logic [63:0] operand;
  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface ntcu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] converted;
  logic        trap;
  modport source (output valid, output converted, output trap, input ready);
  modport sink   (input valid, input converted, input trap, output ready);
endinterface

// ===== hdl/ntcu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcu_decode
// Stage 1: split the operand by opcode, finish integer conversions and float
// specials, and set up magnitude and exponent for the float stages.
// ----------------------------------------------------------------------------
module ntcu_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [4:0]      opcode,
  input  logic [63:0]     operand,
  output logic            vld,
  output ntcu_pkg::pipe_t st
);

  ntcu_pkg::pipe_t st_next;
  logic [63:0]     x;
  logic [63:0]     sx32;
  logic [63:0]     mag;
  logic [7:0]      e32;
  logic [22:0]     f32;
  logic [10:0]     e64;
  logic [51:0]     f64;

  assign x    = operand;
  assign sx32 = {{32{x[31]}}, x[31:0]};
  assign e32  = x[30:23];
  assign f32  = x[22:0];
  assign e64  = x[62:52];
  assign f64  = x[51:0];

  always_comb begin
    st_next      = '0;
    st_next.kind = ntcu_pkg::KIND_INT;
    mag          = '0;
    unique case (ntcu_pkg::op_t'(opcode))
      ntcu_pkg::OP_I32_F64, ntcu_pkg::OP_I32_F32: begin
        st_next.neg  = x[31];
        mag          = x[31] ? (64'd0 - sx32) : sx32;
        st_next.m    = mag;
        st_next.to32 = (ntcu_pkg::op_t'(opcode) == ntcu_pkg::OP_I32_F32);
        if (mag != 64'd0) st_next.kind = ntcu_pkg::KIND_PACK;
      end
      ntcu_pkg::OP_I64_F64, ntcu_pkg::OP_I64_F32: begin
        st_next.neg  = x[63];
        mag          = x[63] ? (64'd0 - x) : x;
        st_next.m    = mag;
        st_next.to32 = (ntcu_pkg::op_t'(opcode) == ntcu_pkg::OP_I64_F32);
        if (mag != 64'd0) st_next.kind = ntcu_pkg::KIND_PACK;
      end
      ntcu_pkg::OP_F32_F64: begin
        st_next.neg = x[31];
        if (e32 == 8'hFF) begin
          st_next.res = {x[31], 11'h7FF, (f32 != 23'd0), f32[21:0], 29'd0};
        end else begin
          st_next.m    = {40'd0, (e32 != 8'd0), f32};
          st_next.q    = (e32 != 8'd0) ? (ntcu_pkg::QW'(e32) - 13'sd150) : -13'sd149;
          st_next.res  = {x[31], 63'd0};
          if (st_next.m != 64'd0) st_next.kind = ntcu_pkg::KIND_PACK;
        end
      end
      ntcu_pkg::OP_F64_F32: begin
        st_next.neg  = x[63];
        st_next.to32 = 1'b1;
        if (e64 == 11'h7FF) begin
          st_next.res = {32'd0, x[63], 8'hFF, (f64 != 52'd0), f64[50:29]};
        end else begin
          st_next.m   = {11'd0, (e64 != 11'd0), f64};
          st_next.q   = (e64 != 11'd0) ? (ntcu_pkg::QW'(e64) - 13'sd1075) : -13'sd1074;
          st_next.res = {32'd0, x[63], 31'd0};
          if (st_next.m != 64'd0) st_next.kind = ntcu_pkg::KIND_PACK;
        end
      end
      ntcu_pkg::OP_F64_I32, ntcu_pkg::OP_F64_I64: begin
        st_next.neg = x[63];
        st_next.n64 = (ntcu_pkg::op_t'(opcode) == ntcu_pkg::OP_F64_I64);
        if (e64 == 11'h7FF) begin
          st_next.trap = 1'b1;
        end else begin
          st_next.kind = ntcu_pkg::KIND_F2I;
          st_next.m    = {11'd0, (e64 != 11'd0), f64};
          st_next.q    = (e64 != 11'd0) ? (ntcu_pkg::QW'(e64) - 13'sd1075) : -13'sd1074;
        end
      end
      ntcu_pkg::OP_F32_I32, ntcu_pkg::OP_F32_I64: begin
        st_next.neg = x[31];
        st_next.n64 = (ntcu_pkg::op_t'(opcode) == ntcu_pkg::OP_F32_I64);
        if (e32 == 8'hFF) begin
          st_next.trap = 1'b1;
        end else begin
          st_next.kind = ntcu_pkg::KIND_F2I;
          st_next.m    = {40'd0, (e32 != 8'd0), f32};
          st_next.q    = (e32 != 8'd0) ? (ntcu_pkg::QW'(e32) - 13'sd150) : -13'sd149;
        end
      end
      ntcu_pkg::OP_I32_I64: st_next.res = sx32;
      ntcu_pkg::OP_I64_I32: begin
        if (sx32 != x) st_next.trap = 1'b1;
        else           st_next.res  = {32'd0, x[31:0]};
      end
      ntcu_pkg::OP_I8_I32:  st_next.res = {32'd0, {24{x[7]}}, x[7:0]};
      ntcu_pkg::OP_I16_I32: st_next.res = {32'd0, {16{x[15]}}, x[15:0]};
      ntcu_pkg::OP_I8_I64:  st_next.res = {{56{x[7]}}, x[7:0]};
      ntcu_pkg::OP_I16_I64: st_next.res = {{48{x[15]}}, x[15:0]};
      ntcu_pkg::OP_U8_U32, ntcu_pkg::OP_U8_U64:   st_next.res = {56'd0, x[7:0]};
      ntcu_pkg::OP_U16_U32, ntcu_pkg::OP_U16_U64: st_next.res = {48'd0, x[15:0]};
      ntcu_pkg::OP_U32_U64, ntcu_pkg::OP_U32_I64: st_next.res = {32'd0, x[31:0]};
      ntcu_pkg::OP_I32_I8: begin
        if (x[31:7] != {25{x[7]}}) st_next.trap = 1'b1;
        else                       st_next.res  = {56'd0, x[7:0]};
      end
      ntcu_pkg::OP_I32_I16: begin
        if (x[31:15] != {17{x[15]}}) st_next.trap = 1'b1;
        else                         st_next.res  = {48'd0, x[15:0]};
      end
      ntcu_pkg::OP_U32_U8: begin
        if (x[31:8] != 24'd0) st_next.trap = 1'b1;
        else                  st_next.res  = {56'd0, x[7:0]};
      end
      ntcu_pkg::OP_U32_U16: begin
        if (x[31:16] != 16'd0) st_next.trap = 1'b1;
        else                   st_next.res  = {48'd0, x[15:0]};
      end
      ntcu_pkg::OP_I32_U32, ntcu_pkg::OP_U32_I32: begin
        if (x[31]) st_next.trap = 1'b1;
        else       st_next.res  = {32'd0, x[31:0]};
      end
      ntcu_pkg::OP_I64_U64, ntcu_pkg::OP_U64_I64: begin
        if (x[63]) st_next.trap = 1'b1;
        else       st_next.res  = x;
      end
      default: st_next.trap = 1'b1;
    endcase
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
    if (en) begin
      st <= st_next;
    end
  end

endmodule

// ===== hdl/ntcu_align.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcu_align
// Stages 2 and 3: leading-zero count and normalize for packing; shift to
// integer and range check for float-to-int.
// ----------------------------------------------------------------------------
module ntcu_align (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  ntcu_pkg::pipe_t in_st,
  output logic            vld,
  output ntcu_pkg::pipe_t st
);

  logic            vld2;
  ntcu_pkg::pipe_t st2;
  ntcu_pkg::pipe_t st2_next;
  ntcu_pkg::pipe_t st_next;

  logic [5:0]                    sh;
  logic signed [ntcu_pkg::QW-1:0] d;
  logic signed [ntcu_pkg::QW-1:0] bexp;
  logic signed [ntcu_pkg::QW-1:0] dd;
  logic [63:0]                   lim;
  logic [63:0]                   sbit;

  function automatic logic [5:0] lzc(input logic [63:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 6'(63 - i);
    end
    return n;
  endfunction

  // Stage 2: count zeros, or shift the float to an integer
  always_comb begin
    st2_next = in_st;
    sh       = 6'(7'd64 - 7'(in_st.q));
    d        = -in_st.q;
    case (in_st.kind)
      ntcu_pkg::KIND_PACK: st2_next.lz = lzc(in_st.m);
      ntcu_pkg::KIND_F2I: begin
        if (!in_st.q[ntcu_pkg::QW-1]) begin
          if (in_st.q >= ntcu_pkg::DROP_FULL) begin
            st2_next.big = (in_st.m != 64'd0);
            st2_next.m   = 64'd0;
          end else begin
            st2_next.big = (in_st.q != '0) && ((in_st.m >> sh) != 64'd0);
            st2_next.m   = in_st.m << in_st.q[5:0];
          end
        end else if (d >= ntcu_pkg::DROP_FULL) begin
          st2_next.m    = 64'd0;
          st2_next.frac = (in_st.m != 64'd0);
        end else begin
          st2_next.m    = in_st.m >> d[5:0];
          st2_next.frac = (in_st.m & ((64'd1 << d[5:0]) - 64'd1)) != 64'd0;
        end
      end
      default: ;
    endcase
  end

  // Stage 3: normalize and find the drop count, or check the range
  always_comb begin
    st_next = st2;
    bexp    = st2.q - ntcu_pkg::QW'(st2.lz) + 13'sd63
            + (st2.to32 ? ntcu_pkg::BIAS32 : ntcu_pkg::BIAS64);
    dd      = (st2.to32 ? ntcu_pkg::DROP32 : ntcu_pkg::DROP64)
            + ((bexp < 13'sd1) ? (13'sd1 - bexp) : 13'sd0);
    lim     = st2.n64 ? (64'd1 << 63) : (64'd1 << 31);
    sbit    = st2.to32 ? {32'd0, st2.neg, 31'd0} : {st2.neg, 63'd0};
    case (st2.kind)
      ntcu_pkg::KIND_PACK: begin
        st_next.m = st2.m << st2.lz;
        st_next.q = bexp;
        if (dd > ntcu_pkg::DROP_FULL) begin
          st_next.kind = ntcu_pkg::KIND_INT;
          st_next.res  = sbit;
        end else begin
          st_next.drop = 7'(dd);
        end
      end
      ntcu_pkg::KIND_F2I: begin
        st_next.trap = st2.big
          || (!st2.neg && (st2.m > lim - 64'd1 || (st2.m == lim - 64'd1 && st2.frac)))
          || (st2.neg && (st2.m > lim || (st2.m == lim && st2.frac)));
      end
      default: ;
    endcase
  end

  // Advance both stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
      vld  <= 1'b0;
    end else if (en) begin
      vld2 <= in_vld;
      vld  <= vld2;
    end
    if (en) begin
      st2 <= st2_next;
      st  <= st_next;
    end
  end

endmodule

// ===== hdl/ntcu_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcu_round
// Stages 4 and 5: cut off dropped bits with guard and sticky, then round to
// nearest even and pack; negate and mask float-to-int results.
// ----------------------------------------------------------------------------
module ntcu_round (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  ntcu_pkg::pipe_t in_st,
  output logic            vld,
  output ntcu_pkg::pipe_t st
);

  logic            vld4;
  ntcu_pkg::pipe_t st4;
  ntcu_pkg::pipe_t st4_next;
  ntcu_pkg::pipe_t st_next;

  logic [5:0]  d1;
  logic [63:0] t2;
  logic [63:0] kept;
  logic [63:0] sbit;
  logic [63:0] expf;
  logic        inc;

  // Stage 4: split kept bits from the rest
  always_comb begin
    st4_next = in_st;
    d1       = 6'(in_st.drop - 7'd1);
    t2       = in_st.neg ? (64'd0 - in_st.m) : in_st.m;
    case (in_st.kind)
      ntcu_pkg::KIND_PACK: begin
        st4_next.m      = in_st.drop[6] ? 64'd0 : (in_st.m >> in_st.drop[5:0]);
        st4_next.guard  = in_st.m[d1];
        st4_next.sticky = (in_st.m & ((64'd1 << d1) - 64'd1)) != 64'd0;
      end
      ntcu_pkg::KIND_F2I: begin
        st4_next.kind = ntcu_pkg::KIND_INT;
        st4_next.res  = in_st.n64 ? t2 : {32'd0, t2[31:0]};
      end
      default: ;
    endcase
  end

  // Stage 5: round and pack
  always_comb begin
    st_next = st4;
    inc     = st4.guard && (st4.sticky || st4.m[0]);
    kept    = st4.m + {63'd0, inc};
    sbit    = st4.to32 ? {32'd0, st4.neg, 31'd0} : {st4.neg, 63'd0};
    expf    = st4.to32 ? (64'(st4.q - 13'sd1) << 23) : (64'(st4.q - 13'sd1) << 52);
    if (st4.kind == ntcu_pkg::KIND_PACK) begin
      st_next.kind = ntcu_pkg::KIND_INT;
      if (st4.q >= (st4.to32 ? ntcu_pkg::MAXEXP32 : ntcu_pkg::MAXEXP64)) begin
        st_next.res = sbit | (st4.to32 ? {32'd0, 1'b0, 8'hFF, 23'd0}
                                       : {1'b0, 11'h7FF, 52'd0});
      end else if (st4.q < 13'sd1) begin
        st_next.res = sbit | kept;
      end else begin
        st_next.res = sbit | (expf + kept);
      end
    end
  end

  // Advance both stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
      vld  <= 1'b0;
    end else if (en) begin
      vld4 <= in_vld;
      vld  <= vld4;
    end
    if (en) begin
      st4 <= st4_next;
      st  <= st_next;
    end
  end

endmodule

// ===== hdl/numeric_type_convert_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_type_convert_unit
// Converts among i8..i64, u8..u64, f32 and f64 in a five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   in_word carries opcode and operand; out_word carries converted and trap,
//   one result word for every request word, in order.
//   The accepting edge loads the first of five register stages, and
//   out_word.valid rises when the word reaches the last stage; one word
//   is taken every cycle while the receiver keeps up. The five register
//   stages are: decode, leading-zero count or float-to-int shift, normalize
//   or range check, bit cut with guard/sticky, round and pack.
//   When out_word.ready is low with a result waiting, the whole pipeline
//   holds and in_word.ready drops; nothing is lost or repeated. A free slot
//   at the output keeps the pipeline moving.
//   A trapped conversion (NaN, infinity, out of range, unknown opcode)
//   returns converted = 0 with trap = 1.
//   Reset (rst, synchronous) empties all stages; no clearing pass follows.
// ----------------------------------------------------------------------------
module numeric_type_convert_unit (
  input  logic       clk,
  input  logic       rst,
  ntcu_in_if.sink    in_word,
  ntcu_out_if.source out_word
);

  logic            en;
  logic            v1;
  logic            v3;
  logic            v5;
  ntcu_pkg::pipe_t s1;
  ntcu_pkg::pipe_t s3;
  ntcu_pkg::pipe_t s5;

  // Advance whenever the output slot is empty or being taken
  assign en            = !v5 || out_word.ready;
  assign in_word.ready = en;

  ntcu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_word.valid),
    .opcode  (in_word.opcode),
    .operand (in_word.operand),
    .vld     (v1),
    .st      (s1)
  );

  ntcu_align u_align (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (v1),
    .in_st  (s1),
    .vld    (v3),
    .st     (s3)
  );

  ntcu_round u_round (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (v3),
    .in_st  (s3),
    .vld    (v5),
    .st     (s5)
  );

  // Drive the result word; zero the pattern on a trap
  assign out_word.valid     = v5;
  assign out_word.trap      = s5.trap;
  assign out_word.converted = s5.trap ? 64'd0 : s5.res;

endmodule

// ===== hdl/ntcu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcu_checker
// Port-level checks of the conversion unit, bound to the top level.
// ----------------------------------------------------------------------------
module ntcu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] converted,
  input logic        trap
);

  // Hold a result word until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // Keep a stalled result word unchanged
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(converted) && $stable(trap))
    else $error("stalled result word changed");

  // Refuse input only behind a stalled result
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without a stall");

  // Zero the pattern on a trap
  a_trap_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && trap |-> converted == 64'd0)
    else $error("trapped word carries a value");

endmodule

bind numeric_type_convert_unit ntcu_checker u_ntcu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_word.ready),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .converted (out_word.converted),
  .trap      (out_word.trap)
);
